FILE: sv/ps2dec_pkg.sv
// Shared constants, byte codes and the key translation ROM of the
// PS/2 scan code set 2 decoder. No dependencies.
package ps2dec_pkg;

  localparam int KEY_SLOTS  = 256;
  localparam int KEY_ADDR_W = $clog2(KEY_SLOTS);

  localparam logic [7:0] BYTE_REPLY_MIN = 8'hFA;
  localparam logic [7:0] BYTE_EXTENDED  = 8'hE0;
  localparam logic [7:0] BYTE_BREAK     = 8'hF0;

  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_REPLY   = 2'd2;

  typedef logic [6:0] key_code_t;

  // Only the lower half of the byte range has translations; the upper half reads 0.
  localparam key_code_t KEY_ROM [128] = '{
    7'h00, 7'h72, 7'h00, 7'h6E, 7'h6C, 7'h6A, 7'h6B, 7'h75,
    7'h00, 7'h73, 7'h71, 7'h6F, 7'h6D, 7'h09, 7'h60, 7'h00,
    7'h00, 7'h17, 7'h0E, 7'h00, 7'h15, 7'h51, 7'h31, 7'h00,
    7'h00, 7'h00, 7'h5A, 7'h53, 7'h41, 7'h57, 7'h32, 7'h00,
    7'h00, 7'h43, 7'h58, 7'h44, 7'h45, 7'h34, 7'h33, 7'h00,
    7'h00, 7'h20, 7'h56, 7'h46, 7'h54, 7'h52, 7'h35, 7'h00,
    7'h00, 7'h4E, 7'h42, 7'h48, 7'h47, 7'h59, 7'h36, 7'h00,
    7'h00, 7'h00, 7'h4D, 7'h4A, 7'h55, 7'h37, 7'h38, 7'h00,
    7'h00, 7'h2C, 7'h4B, 7'h49, 7'h4F, 7'h30, 7'h39, 7'h00,
    7'h00, 7'h2E, 7'h2F, 7'h4C, 7'h3B, 7'h50, 7'h2D, 7'h00,
    7'h00, 7'h00, 7'h27, 7'h00, 7'h5B, 7'h3D, 7'h00, 7'h00,
    7'h1C, 7'h0F, 7'h0D, 7'h5D, 7'h00, 7'h5C, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h08, 7'h00,
    7'h00, 7'h6B, 7'h00, 7'h6E, 7'h71, 7'h00, 7'h00, 7'h00,
    7'h6A, 7'h07, 7'h6C, 7'h6F, 7'h70, 7'h72, 7'h1B, 7'h01,
    7'h74, 7'h05, 7'h6D, 7'h04, 7'h03, 7'h73, 7'h68, 7'h00
  };

  function automatic key_code_t key_xlate(input logic [7:0] scan);
    return scan[7] ? 7'd0 : KEY_ROM[scan[6:0]];
  endfunction

endpackage

FILE: sv/ps2_scancode_set2_decoder_unit.sv
// Bytes are held in the decode stage register; results go on to the output register.
// Throughput: one byte per cycle while out_ready is high and no sweep runs; the key
// map's single read port and the read-modify-write loop around it set that figure.
// Reset (rst_n low, synchronous) clears control state and starts a sweep that zeroes
// all 256 key map entries, one entry per cycle; no beat is accepted during the sweep.
// Uses ps2dec_pkg for byte codes, event kinds and the translation ROM.
module ps2_scancode_set2_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_scan_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_kind,
  output logic [6:0] out_key_code,
  output logic [7:0] out_reply_byte
);

  // The pressed-key map lives in a 1-bit-wide synchronous memory, one entry per byte.
  logic key_map_mem [ps2dec_pkg::KEY_SLOTS];

  // Clearing sweep after reset.
  logic                              clr_busy_r, clr_busy_nxt;
  logic [ps2dec_pkg::KEY_ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  // Decode stage: the byte whose map entry was read at the accepting edge.
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       mem_rd_r;
  logic       fwd_hit_r;
  logic       fwd_data_r;

  logic       break_pending_r, break_pending_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r;
  logic [6:0] out_code_r;
  logic [7:0] out_reply_r;

  // Map write port, shared by the clearing sweep and the decode stage.
  logic                              wr_en;
  logic [ps2dec_pkg::KEY_ADDR_W-1:0] wr_addr;
  logic                              wr_data;

  logic in_fire;
  logic s1_go;
  logic key_down;
  logic is_reply, is_ext, is_brk, is_key;
  logic upd_en;
  logic has_result;
  logic [1:0] res_kind;

  // The decode stage moves on whenever the output register is free or being drained.
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_busy_r && (!s1_valid_r || s1_go);
  assign in_fire  = in_valid && in_ready;

  // The map entry as the decode stage must see it: if the previous byte wrote the same
  // entry at the edge where this one was read, the memory still returned the old bit,
  // so the forwarded write data takes its place.
  assign key_down = fwd_hit_r ? fwd_data_r : mem_rd_r;

  always_comb begin
    is_reply = (s1_byte_r >= ps2dec_pkg::BYTE_REPLY_MIN);
    is_ext   = (s1_byte_r == ps2dec_pkg::BYTE_EXTENDED);
    is_brk   = (s1_byte_r == ps2dec_pkg::BYTE_BREAK);
    is_key   = !is_reply && !is_ext && !is_brk;

    // A key byte updates the map on a release, or on a press of a key not yet down.
    // A press of a key already down is a typematic repeat and gives nothing.
    upd_en     = is_key && (break_pending_r || !key_down);
    has_result = is_reply || upd_en;
    if (is_reply) begin
      res_kind = ps2dec_pkg::KIND_REPLY;
    end else if (break_pending_r) begin
      res_kind = ps2dec_pkg::KIND_RELEASE;
    end else begin
      res_kind = ps2dec_pkg::KIND_PRESS;
    end

    break_pending_nxt = break_pending_r;
    if (s1_go) begin
      if (is_brk) begin
        break_pending_nxt = 1'b1;
      end else if (is_key) begin
        break_pending_nxt = 1'b0;
      end
    end

    if (clr_busy_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = 1'b0;
    end else begin
      wr_en   = s1_go && upd_en;
      wr_addr = s1_byte_r[ps2dec_pkg::KEY_ADDR_W-1:0];
      wr_data = !break_pending_r;
    end

    clr_busy_nxt = clr_busy_r && (clr_addr_r != {ps2dec_pkg::KEY_ADDR_W{1'b1}});
    clr_addr_nxt = clr_busy_r ? clr_addr_r + 1'b1 : clr_addr_r;

    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (s1_go && has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Key map memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_map_mem[wr_addr] <= wr_data;
    end
    if (in_fire) begin
      mem_rd_r <= key_map_mem[in_scan_byte[ps2dec_pkg::KEY_ADDR_W-1:0]];
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r  <= in_scan_byte;
      fwd_hit_r  <= wr_en && (wr_addr == in_scan_byte[ps2dec_pkg::KEY_ADDR_W-1:0]);
      fwd_data_r <= wr_data;
    end
    if (s1_go && has_result) begin
      out_kind_r  <= res_kind;
      out_code_r  <= is_reply ? 7'd0 : ps2dec_pkg::key_xlate(s1_byte_r);
      out_reply_r <= is_reply ? s1_byte_r : 8'd0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r      <= 1'b1;
      clr_addr_r      <= '0;
      s1_valid_r      <= 1'b0;
      break_pending_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      clr_busy_r      <= clr_busy_nxt;
      clr_addr_r      <= clr_addr_nxt;
      s1_valid_r      <= s1_valid_nxt;
      break_pending_r <= break_pending_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_key_code   = out_code_r;
  assign out_reply_byte = out_reply_r;

endmodule
